/* hw/rtl/rrtd_pkg.sv */
// shared types and constants for the rr interval tachycardia detector
// no dependencies; imported by rrtd_cfg, rrtd_window and the top level

package rrtd_pkg;

    localparam int RR_W      = 16;   // interval and threshold width
    localparam int DETECT_W  = 4;    // detect count width
    localparam int TIMER_W   = 24;   // timeout and normal period width
    localparam int SUM_W     = 32;   // period sum width
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    typedef struct packed {
        logic [RR_W-1:0]     rr_threshold;
        logic [DETECT_W-1:0] detect_count;
        logic [TIMER_W-1:0]  no_r_timeout;
        logic [TIMER_W-1:0]  normal_duration;
    } rrtd_cfg_t;

endpackage

/* hw/rtl/rrtd_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module rrtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/rrtd_cfg.sv */
// apb configuration registers of the detector
// depends on rrtd_pkg

module rrtd_cfg
    import rrtd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output rrtd_cfg_t         cfg,
    output logic              threshold_written
);

    localparam logic [1:0] REG_RR_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_DETECT_COUNT    = 2'd1;
    localparam logic [1:0] REG_NO_R_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_NORMAL_DURATION = 2'd3;

    rrtd_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[3:2];
    assign cfg       = cfg_reg;
    assign threshold_written = wr_en && (reg_index == REG_RR_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rr_threshold    <= RR_W'(360);
            cfg_reg.detect_count    <= DETECT_W'(6);
            cfg_reg.no_r_timeout    <= TIMER_W'(10000);
            cfg_reg.normal_duration <= TIMER_W'(20000);
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_RR_THRESHOLD:    cfg_reg.rr_threshold    <= pwdata[RR_W-1:0];
                REG_DETECT_COUNT:    cfg_reg.detect_count    <= pwdata[DETECT_W-1:0];
                REG_NO_R_TIMEOUT:    cfg_reg.no_r_timeout    <= pwdata[TIMER_W-1:0];
                REG_NORMAL_DURATION: cfg_reg.normal_duration <= pwdata[TIMER_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_RR_THRESHOLD:    prdata = APB_DW'(cfg_reg.rr_threshold);
            REG_DETECT_COUNT:    prdata = APB_DW'(cfg_reg.detect_count);
            REG_NO_R_TIMEOUT:    prdata = APB_DW'(cfg_reg.no_r_timeout);
            REG_NORMAL_DURATION: prdata = APB_DW'(cfg_reg.normal_duration);
            default:             prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/rrtd_window.sv */
// interval window: circular buffer in ram, fill count, running short count
// and a recount sweep after a threshold change; depends on rrtd_pkg, rrtd_ram

module rrtd_window
    import rrtd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [RR_W-1:0]                    rr_threshold,
    input  logic                               threshold_written,
    input  logic                               rd_req,
    input  logic                               push,
    input  logic [RR_W-1:0]                    push_data,
    output logic                               busy,
    output logic                               full,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]  short_count,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]  push_count
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [AW-1:0]   wr_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   count_reg;
    logic            issue_reg;
    logic [AW-1:0]   issue_idx_reg;
    logic            chk_reg;
    logic [AW-1:0]   chk_idx_reg;
    logic [CW-1:0]   acc_reg;

    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [RR_W-1:0] ram_rdata;
    logic [RR_W-1:0] old_value;
    logic            old_short;
    logic            new_short;
    logic            chk_valid;
    logic [RR_W-1:0] chk_value;
    logic            chk_short;
    logic [CW-1:0]   acc_next;

    assign ram_re    = rd_req | issue_reg;
    assign ram_raddr = issue_reg ? issue_idx_reg : wr_ptr_reg;

    rrtd_ram #(
        .WIDTH (RR_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (push_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full        = (fill_reg == CW'(WINDOW_DEPTH));
    assign busy        = issue_reg | chk_reg;
    assign short_count = count_reg;

    // entries not yet written read as zero
    assign old_value  = full ? ram_rdata : '0;
    assign old_short  = (old_value <= rr_threshold);
    assign new_short  = (push_data <= rr_threshold);
    assign push_count = CW'(count_reg + CW'(new_short) - CW'(old_short));

    assign chk_valid = full || (CW'(chk_idx_reg) < fill_reg);
    assign chk_value = chk_valid ? ram_rdata : '0;
    assign chk_short = (chk_value <= rr_threshold);
    assign acc_next  = CW'(acc_reg + CW'(chk_short));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            count_reg     <= CW'(WINDOW_DEPTH);
            issue_reg     <= 1'b0;
            issue_idx_reg <= '0;
            chk_reg       <= 1'b0;
            chk_idx_reg   <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
                if (!full)
                begin
                    fill_reg <= CW'(fill_reg + 1'b1);
                end
                count_reg <= push_count;
            end

            if (threshold_written)
            begin
                // restart the recount with the new threshold
                issue_reg     <= 1'b1;
                issue_idx_reg <= '0;
                chk_reg       <= 1'b0;
                acc_reg       <= '0;
            end
            else
            begin
                if (issue_reg)
                begin
                    issue_idx_reg <= AW'(issue_idx_reg + 1'b1);
                    chk_idx_reg   <= issue_idx_reg;
                    if (issue_idx_reg == AW'(WINDOW_DEPTH - 1))
                    begin
                        issue_reg <= 1'b0;
                    end
                end
                chk_reg <= issue_reg;
                if (chk_reg)
                begin
                    acc_reg <= acc_next;
                    if (chk_idx_reg == AW'(WINDOW_DEPTH - 1))
                    begin
                        count_reg <= acc_next;
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/rr_interval_tachycardia_detector_unit.sv */
// Top level of the rr interval tachycardia detector.
// Depends on rrtd_pkg, rrtd_cfg, rrtd_window (and rrtd_ram below it).
//
// One ECG marker sample (is_r_peak, block_start) enters per transfer on the
// sample channel; one result (detect_state, state_event, rr_interval,
// short_count) leaves per sample on the result channel. A transfer happens
// when valid is high and stall is low.
// A sample is taken when it transfers; for an R peak, the window entry it
// evicts is read from the window ram in that cycle. The calc state that
// follows updates all state and loads the result register, and sample_stall
// stays high until it does, so a new sample waits for that update.
// While a result waits under result_stall, the next sample is still taken;
// its update then waits until the result register is free.
// A write of rr_threshold starts a recount over the window ram, during
// which sample_stall is high.
// After reset the window reads as all zero intervals, the detector is idle,
// and no clearing pass is needed: a fill count marks unwritten entries.
// Registers: 0 rr_threshold, 1 detect_count, 2 no_r_timeout,
// 3 normal_duration, at byte addresses 0, 4, 8, 12.

module rr_interval_tachycardia_detector_unit
    import rrtd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  logic              is_r_peak,
    input  logic              block_start,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [1:0]        detect_state,
    output logic              state_event,
    output logic [RR_W-1:0]   rr_interval,
    output logic [3:0]        short_count
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int NW = TIMER_W + 1;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_BEGIN   = 2'd1;
    localparam logic [1:0] MODE_ONGOING = 2'd2;
    localparam logic [1:0] MODE_FINISH  = 2'd3;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    rrtd_cfg_t cfg;
    logic      threshold_written;

    logic [CW-1:0] win_count;
    logic [CW-1:0] win_push_count;
    logic          win_busy;
    logic          win_full;

    logic                   state_reg;
    logic                   peak_reg;
    logic                   bstart_reg;
    logic [1:0]             mode_reg, mode_next;
    logic [RR_W-1:0]        since_reg, since_next;
    logic [TIMER_W-1:0]     no_peak_reg, no_peak_next;
    logic signed [NW-1:0]   normal_reg, normal_next;
    logic [SUM_W-1:0]       psum_reg, psum_next;
    logic [RR_W-1:0]        pcount_reg, pcount_next;
    logic [SUM_W-1:0]       prod_reg;
    logic                   event_next;
    logic [RR_W-1:0]        newest_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_state_reg;
    logic                   out_event_reg;
    logic [RR_W-1:0]        out_rr_reg;
    logic [3:0]             out_short_reg;

    logic                   accept;
    logic                   commit;
    logic                   push;
    logic [CW-1:0]          count_now;
    logic [CW+3:0]          count_ext;
    logic [CW+3:0]          detect_ext;
    logic [SUM_W:0]         sum_wide;

    rrtd_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .cfg               (cfg),
        .threshold_written (threshold_written)
    );

    assign sample_stall = (state_reg != ST_IDLE) | win_busy;
    assign accept       = sample_valid & ~sample_stall;
    assign commit       = (state_reg == ST_CALC) & (~out_valid_reg | ~result_stall);
    assign push         = commit & peak_reg;

    rrtd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk               (clk),
        .rst_n             (rst_n),
        .rr_threshold      (cfg.rr_threshold),
        .threshold_written (threshold_written),
        .rd_req            (accept & is_r_peak),
        .push              (push),
        .push_data         (since_reg),
        .busy              (win_busy),
        .full              (win_full),
        .short_count       (win_count),
        .push_count        (win_push_count)
    );

    assign count_now  = peak_reg ? win_push_count : win_count;
    assign count_ext  = {4'b0, count_now};
    assign detect_ext = (CW + 4)'(cfg.detect_count);
    assign sum_wide   = {1'b0, psum_reg} + (SUM_W + 1)'(since_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        since_next  = since_reg;
        no_peak_next = no_peak_reg;
        normal_next = normal_reg;
        psum_next   = psum_reg;
        pcount_next = pcount_reg;
        event_next  = 1'b0;

        if (bstart_reg && (mode_reg == MODE_FINISH))
        begin
            mode_next = MODE_IDLE;
        end
        if (no_peak_reg != '0)
        begin
            no_peak_next = TIMER_W'(no_peak_reg - 1'b1);
        end
        if (normal_reg >= 0)
        begin
            normal_next = NW'(normal_reg - 1);
        end

        if (peak_reg)
        begin
            since_next   = RR_W'(1);
            no_peak_next = cfg.no_r_timeout;
            if (win_full && (count_ext >= detect_ext))
            begin
                mode_next   = (mode_next == MODE_IDLE) ? MODE_BEGIN : MODE_ONGOING;
                event_next  = 1'b1;
                pcount_next = '0;
                psum_next   = '0;
                normal_next = signed'({1'b0, cfg.normal_duration});
            end
            if (mode_next != MODE_IDLE)
            begin
                if (normal_next >= 0)
                begin
                    if (pcount_next != '1)
                    begin
                        pcount_next = RR_W'(pcount_next + 1'b1);
                    end
                    // a fresh period starts the sum at the interval itself
                    if (event_next)
                    begin
                        psum_next = SUM_W'(since_reg);
                    end
                    else
                    begin
                        psum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                    end
                end
                else if ((mode_next == MODE_ONGOING) && (psum_reg >= prod_reg))
                begin
                    mode_next  = MODE_FINISH;
                    event_next = 1'b1;
                end
            end
        end
        else if (since_reg != '1)
        begin
            since_next = RR_W'(since_reg + 1'b1);
        end

        if ((no_peak_next == '0) && (mode_next == MODE_ONGOING))
        begin
            mode_next  = MODE_FINISH;
            event_next = 1'b1;
        end
    end

    // threshold times period count, registered ahead of its use
    always_ff @(posedge clk)
    begin
        prod_reg <= SUM_W'(cfg.rr_threshold) * SUM_W'(pcount_reg);
        if (accept)
        begin
            peak_reg   <= is_r_peak;
            bstart_reg <= block_start;
        end
        if (commit)
        begin
            out_state_reg <= mode_next;
            out_event_reg <= event_next;
            out_rr_reg    <= peak_reg ? since_reg : newest_reg;
            out_short_reg <= (count_ext > (CW + 4)'(15)) ? 4'd15 : count_ext[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_IDLE;
            since_reg     <= '0;
            no_peak_reg   <= '0;
            normal_reg    <= '1;
            psum_reg      <= '0;
            pcount_reg    <= '0;
            newest_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (commit)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (commit)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                since_reg     <= since_next;
                no_peak_reg   <= no_peak_next;
                normal_reg    <= normal_next;
                psum_reg      <= psum_next;
                pcount_reg    <= pcount_next;
                if (peak_reg)
                begin
                    newest_reg <= since_reg;
                end
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign detect_state = out_state_reg;
    assign state_event  = out_event_reg;
    assign rr_interval  = out_rr_reg;
    assign short_count  = out_short_reg;

endmodule
